// ----- hw/rtl/stl_pkg.sv -----
package stl_pkg;

  // Result queue depth: one slot draining plus room for a two-result request.
  localparam int unsigned QueueDepth = 3;
  localparam int unsigned PtrW       = 2;
  localparam int unsigned CntW       = 2;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChMinus     = 8'h2D;
  localparam logic [7:0] ChDot       = 8'h2E;
  localparam logic [7:0] ChSemi      = 8'h3B;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChQuote     = 8'h27;
  localparam logic [7:0] ChOpen      = 8'h28;
  localparam logic [7:0] ChClose     = 8'h29;

  typedef enum logic [7:0] {
    ModeIdle    = 8'b0000_0001,
    ModeSymbol  = 8'b0000_0010,
    ModeInt     = 8'b0000_0100,
    ModeOpen    = 8'b0000_1000,
    ModeClose   = 8'b0001_0000,
    ModeQuote   = 8'b0010_0000,
    ModeReal    = 8'b0100_0000,
    ModeComment = 8'b1000_0000
  } lex_mode_e;

  typedef enum logic [2:0] {
    TokSymbol = 3'd0,
    TokInt    = 3'd1,
    TokOpen   = 3'd2,
    TokClose  = 3'd3,
    TokQuote  = 3'd4,
    TokReal   = 3'd5
  } tok_type_e;

  typedef enum logic {
    KindToken   = 1'b0,
    KindInvalid = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e     kind;
    logic [7:0] data;
    tok_type_e tok_type;
    logic      tok_end;
    logic      run_last;
  } result_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic sym_start(input logic [7:0] c);
    return is_letter(c) || c == 8'h2B || c == 8'h2A || c == 8'h2F || c == 8'h25 ||
           c == 8'h21 || c == 8'h3F || c == 8'h26 || c == 8'h5E || c == 8'h7C ||
           c == 8'h3C || c == 8'h3E;
  endfunction

  function automatic logic sym_more(input logic [7:0] c);
    return sym_start(c) || c == ChMinus || c == ChBackslash;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic tok_type_e mode_type(input lex_mode_e m);
    tok_type_e t;
    unique case (m)
      ModeSymbol: t = TokSymbol;
      ModeInt:    t = TokInt;
      ModeOpen:   t = TokOpen;
      ModeClose:  t = TokClose;
      ModeQuote:  t = TokQuote;
      ModeReal:   t = TokReal;
      default:    t = TokSymbol;
    endcase
    return t;
  endfunction

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

endpackage

// ----- hw/rtl/sexpr_token_lexer.sv -----
// S-expression token lexer.
//
// Input channel: one character per request (in_byte_i), or an end-of-text
// marker (end_of_input_i) that flushes the pending token and returns to idle.
// Output channel: token bytes and invalid-character reports, one per request.
// Each token byte leaves one request late, once the next character shows
// whether the token goes on; the last byte carries token_end_o and the final
// token_type_o. run_last_o flags the last result caused by one input request.
//
// A result caused by an input request is written to the result queue and is
// visible in the cycle after the input is accepted. Throughput: one input
// request per cycle while the output does not stall and each input causes at
// most one result. An input that causes two results (a token end plus an
// invalid report) leaves two results waiting in the three-entry result queue.
// With one result taken per cycle, the input stalls while the extra result drains.
// The input stalls whenever two or more results wait in the queue; a stall on
// the output simply holds the queue head. Reset empties the queue, drops the
// pending token byte and puts the lexer in idle.
module sexpr_token_lexer import stl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic [7:0] out_byte_o,
  output logic [2:0] token_type_o,
  output logic       token_end_o,
  output logic       run_last_o
);

  lex_mode_e       mode_q, mode_d;
  logic [7:0]      held_byte_q, held_byte_d;
  logic            held_valid_q, held_valid_d;

  result_t         queue_q [QueueDepth];
  logic [PtrW-1:0] rd_ptr_q, wr_ptr_q;
  logic [CntW-1:0] count_q;

  logic            in_accept, out_accept;
  result_t         res0, res1;
  logic [1:0]      n_res;
  logic            cont;
  tok_type_e       held_type;

  assign in_stall_o  = count_q > CntW'(1);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = count_q != '0;
  assign out_accept  = out_valid_o && !out_stall_i;

  assign held_type = mode_type(mode_q);

  // Decide whether the held token goes on with this character.
  always_comb begin
    cont = 1'b0;
    unique case (mode_q)
      ModeSymbol: cont = sym_more(in_byte_i);
      ModeInt:    cont = is_digit(in_byte_i) || in_byte_i == ChDot;
      ModeReal:   cont = is_digit(in_byte_i);
      default:    cont = 1'b0;
    endcase
  end

  // Lex one character against the current mode; build up to two results.
  always_comb begin
    mode_d       = mode_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    n_res        = 2'd0;
    res0         = '{KindToken, held_byte_q, held_type, 1'b1, 1'b0};
    res1         = '{KindInvalid, in_byte_i, TokSymbol, 1'b0, 1'b0};

    if (end_of_input_i) begin
      // Flush the pending byte as the end of its token.
      n_res        = {1'b0, held_valid_q};
      held_valid_d = 1'b0;
      mode_d       = ModeIdle;
    end else if (mode_q == ModeComment) begin
      if (in_byte_i == ChNewline) begin
        mode_d = ModeIdle;
      end
    end else if (held_valid_q && cont) begin
      // Token goes on: release the held byte unterminated, hold the new one.
      n_res         = 2'd1;
      res0.tok_end  = 1'b0;
      held_byte_d   = in_byte_i;
      if (mode_q == ModeInt && in_byte_i == ChDot) begin
        mode_d = ModeReal;
      end
    end else begin
      // Close any held token, then lex the character fresh.
      n_res        = {1'b0, held_valid_q};
      held_valid_d = 1'b0;
      mode_d       = ModeIdle;
      held_byte_d  = in_byte_i;
      if (sym_start(in_byte_i)) begin
        mode_d       = ModeSymbol;
        held_valid_d = 1'b1;
      end else if (is_digit(in_byte_i) || in_byte_i == ChMinus) begin
        mode_d       = ModeInt;
        held_valid_d = 1'b1;
      end else if (in_byte_i == ChOpen) begin
        mode_d       = ModeOpen;
        held_valid_d = 1'b1;
      end else if (in_byte_i == ChClose) begin
        mode_d       = ModeClose;
        held_valid_d = 1'b1;
      end else if (in_byte_i == ChQuote) begin
        mode_d       = ModeQuote;
        held_valid_d = 1'b1;
      end else if (in_byte_i == ChSemi) begin
        mode_d       = ModeComment;
      end else if (!is_space(in_byte_i)) begin
        // Report the invalid byte after a closed token, or on its own.
        if (held_valid_q) begin
          n_res = 2'd2;
        end else begin
          n_res = 2'd1;
          res0  = res1;
        end
      end
    end

    // Tag the last result of this request.
    if (n_res == 2'd2) begin
      res1.run_last = 1'b1;
    end else begin
      res0.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeIdle;
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
    end else if (in_accept) begin
      mode_q       <= mode_d;
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
    end
  end

  // Result queue: payload slots, no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept && n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (in_accept && n_res == 2'd2) begin
      queue_q[ptr_inc(wr_ptr_q)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (out_accept) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (in_accept) begin
        if (n_res == 2'd1) begin
          wr_ptr_q <= ptr_inc(wr_ptr_q);
        end else if (n_res == 2'd2) begin
          wr_ptr_q <= ptr_inc(ptr_inc(wr_ptr_q));
        end
      end
      count_q <= count_q + (in_accept ? CntW'(n_res) : '0) - CntW'(out_accept);
    end
  end

  assign kind_o       = queue_q[rd_ptr_q].kind;
  assign out_byte_o   = queue_q[rd_ptr_q].data;
  assign token_type_o = queue_q[rd_ptr_q].tok_type;
  assign token_end_o  = queue_q[rd_ptr_q].tok_end;
  assign run_last_o   = queue_q[rd_ptr_q].run_last;

  // Queue never overfills.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("result queue overflow");

  // A held byte only exists in a token mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q |-> (mode_q != ModeIdle && mode_q != ModeComment))
    else $error("held byte outside a token mode");

  // End of input leaves nothing pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && end_of_input_i) |=> (!held_valid_q && mode_q == ModeIdle))
    else $error("end of input did not flush");

  // Invalid reports carry no token type and no end mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KindInvalid) |-> (token_type_o == TokSymbol && !token_end_o))
    else $error("malformed invalid report");

endmodule
